// ===== design/baseline_deviation_trigger_defines.svh =====
// Assertion macros for the baseline deviation trigger.
// Included by the top level. Empty bodies when SYNTHESIS is defined.
`ifndef BASELINE_DEVIATION_TRIGGER_DEFINES_SVH
`define BASELINE_DEVIATION_TRIGGER_DEFINES_SVH

`ifndef SYNTHESIS
`define BDT_ASSERT_NOW(label, ck, rn, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);
`define BDT_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);
`else
`define BDT_ASSERT_NOW(label, ck, rn, ante, cons, msg)
`define BDT_ASSERT_NEXT(label, ck, rn, ante, cons, msg)
`endif

`endif

// ===== design/bdt_pkg.sv =====
// Shared constants, types and functions of the baseline deviation trigger.
// Used by bdt_ring, bdt_core and baseline_deviation_trigger.
package bdt_pkg;

	localparam int SAMPLE_BITS = 24;
	localparam int WINDOW      = 20;
	localparam int THRESH_W    = 24;
	localparam int SLOT_W      = $clog2(WINDOW);
	localparam int SUM_W       = SAMPLE_BITS + $clog2(WINDOW);
	localparam int CMP_W       = (SAMPLE_BITS > THRESH_W) ? SAMPLE_BITS : THRESH_W;

	localparam logic [THRESH_W-1:0]    THRESHOLD_RESET = THRESH_W'(10000);
	localparam logic [SAMPLE_BITS-1:0] SAMPLE_SIGN     = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
	localparam logic [SLOT_W-1:0]      LAST_SLOT       = SLOT_W'(WINDOW - 1);
	localparam logic [SUM_W-1:0]       WIN_SUM         = SUM_W'(WINDOW);
	// Reciprocal of the window, scaled by 2^SUM_W and rounded down.
	localparam logic [SUM_W-1:0]       RECIP           = SUM_W'((longint'(1) << SUM_W) / WINDOW);

	typedef enum logic {
		ACT_SAMPLE = 1'b0,
		ACT_RECAL  = 1'b1
	} action_t;

	typedef struct packed {
		logic [SUM_W-1:0] quot;
		logic [SUM_W-1:0] rem;
	} div_t;

	typedef struct packed {
		logic                   proc;
		logic                   recal;
		logic [SAMPLE_BITS-1:0] sample;
	} core_req_t;

	typedef struct packed {
		logic        has_result;
		logic        trigger;
		logic [15:0] sample_high;
	} core_res_t;

	typedef struct packed {
		logic              filling;
		logic [SLOT_W-1:0] fill_count;
	} core_status_t;

	typedef struct packed {
		logic              we;
		logic [SLOT_W-1:0] waddr;
		logic [SLOT_W-1:0] raddr;
	} ring_req_t;

	// Division by the window: reciprocal multiply, then one correction step.
	function automatic div_t div_window(input logic [SUM_W-1:0] x);
		logic [2*SUM_W-1:0] prod;
		logic [SUM_W-1:0]   q0;
		logic [SUM_W-1:0]   r0;
		div_t               d;
		prod = (2*SUM_W)'(x) * (2*SUM_W)'(RECIP);
		q0   = prod[2*SUM_W-1:SUM_W];
		r0   = x - SUM_W'(q0 * WIN_SUM);
		if (r0 >= WIN_SUM) begin
			d.quot = q0 + SUM_W'(1);
			d.rem  = r0 - WIN_SUM;
		end else begin
			d.quot = q0;
			d.rem  = r0;
		end
		return d;
	endfunction

	// Upper 16 bits of a sample, left aligned when the sample is narrower.
	function automatic logic [15:0] top16(input logic [SAMPLE_BITS-1:0] s);
		logic [SAMPLE_BITS+15:0] w;
		w = {s, 16'h0000};
		return w[SAMPLE_BITS+15 -: 16];
	endfunction

endpackage

// ===== design/bdt_ring.sv =====
// Ring of the most recent samples, one write and one read port.
// Depends on bdt_pkg.
module bdt_ring (
	input  logic                            clk,
	input  bdt_pkg::ring_req_t              req,
	input  logic [bdt_pkg::SAMPLE_BITS-1:0] wdata,
	output logic [bdt_pkg::SAMPLE_BITS-1:0] rdata
);
	import bdt_pkg::*;

	logic [SAMPLE_BITS-1:0] ring_q [WINDOW];

	always_ff @(posedge clk) begin
		if (req.we) begin
			ring_q[req.waddr] <= wdata;
		end
	end

	assign rdata = ring_q[req.raddr];

endmodule

// ===== design/bdt_core.sv =====
// Baseline tracking: fill phase, running sum, baseline and threshold compare.
// Depends on bdt_pkg and bdt_ring.
module bdt_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  bdt_pkg::core_req_t           req,
	input  logic [bdt_pkg::THRESH_W-1:0] threshold,
	output bdt_pkg::core_res_t           res,
	output bdt_pkg::core_status_t        status
);
	import bdt_pkg::*;

	logic [SUM_W-1:0]       sum_q;
	logic [SLOT_W-1:0]      fill_q;
	logic [SLOT_W-1:0]      slot_q;
	logic                   filling_q;

	ring_req_t              ring_req;
	logic [SAMPLE_BITS-1:0] old_sample;
	div_t                   base_div;
	div_t                   fill_div;
	logic [SAMPLE_BITS-1:0] baseline;
	logic [SAMPLE_BITS-1:0] diff;
	logic [SUM_W-1:0]       fill_sum;
	logic [SUM_W:0]         track_add;
	logic [SUM_W-1:0]       track_sum;

	bdt_ring u_ring (
		.clk   (clk),
		.req   (ring_req),
		.wdata (req.sample),
		.rdata (old_sample)
	);

	always_comb begin
		base_div = div_window(sum_q);
		baseline = base_div.quot[SAMPLE_BITS-1:0];
		diff     = (req.sample >= baseline) ? req.sample - baseline : baseline - req.sample;

		fill_sum = sum_q + SUM_W'(req.sample);
		fill_div = div_window(fill_sum);

		track_add = (SUM_W+1)'(sum_q) + (SUM_W+1)'(req.sample);
		track_sum = (track_add >= (SUM_W+1)'(old_sample))
			? SUM_W'(track_add - (SUM_W+1)'(old_sample)) : '0;

		ring_req.we    = req.proc && !req.recal;
		ring_req.waddr = filling_q ? fill_q : slot_q;
		ring_req.raddr = slot_q;

		res.has_result  = req.proc && !req.recal && !filling_q;
		res.trigger     = CMP_W'(diff) > CMP_W'(threshold);
		res.sample_high = top16(req.sample);

		status.filling    = filling_q;
		status.fill_count = fill_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q     <= '0;
			fill_q    <= '0;
			slot_q    <= '0;
			filling_q <= 1'b1;
		end else if (req.proc) begin
			if (req.recal) begin
				sum_q     <= '0;
				fill_q    <= '0;
				slot_q    <= '0;
				filling_q <= 1'b1;
			end else if (filling_q) begin
				if (fill_q == LAST_SLOT) begin
					// Keep only the whole multiple of the window.
					sum_q     <= fill_sum - fill_div.rem;
					fill_q    <= '0;
					slot_q    <= '0;
					filling_q <= 1'b0;
				end else begin
					sum_q  <= fill_sum;
					fill_q <= fill_q + SLOT_W'(1);
				end
			end else begin
				sum_q  <= track_sum;
				slot_q <= (slot_q == LAST_SLOT) ? '0 : slot_q + SLOT_W'(1);
			end
		end
	end

endmodule

// ===== design/baseline_deviation_trigger.sv =====
// Top level of the baseline deviation trigger: handshake, input and result registers.
// Depends on bdt_pkg, bdt_core and baseline_deviation_trigger_defines.svh.
//
// The block takes one word per clock cycle while sample_stall is low and returns its
// result through the input register, where the running sum, the baseline division and
// the ring update are done, and then the result register. The running sum is fed back
// from its own register to the adder, so words may follow each other without gaps.
// After reset or a recalibrate word, the next twenty samples fill the ring and give
// no result; every later sample gives exactly one result. The threshold may only be
// written while no word is in flight.
`include "baseline_deviation_trigger_defines.svh"

module baseline_deviation_trigger (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            threshold_we,
	input  logic [bdt_pkg::THRESH_W-1:0]    threshold_wdata,
	input  logic                            sample_valid,
	output logic                            sample_stall,
	input  logic                            action,
	input  logic [bdt_pkg::SAMPLE_BITS-1:0] raw_code,
	output logic                            result_valid,
	input  logic                            result_stall,
	output logic                            trigger,
	output logic [15:0]                     sample_high
);
	import bdt_pkg::*;

	logic [THRESH_W-1:0]    threshold_q;
	logic                   valid_s1;
	logic                   action_s1;
	logic [SAMPLE_BITS-1:0] sample_s1;
	logic                   valid_s2;
	logic                   trigger_s2;
	logic [15:0]            sample_high_s2;

	logic                   out_free;
	logic                   proc;
	logic                   accept;
	core_req_t              core_req;
	core_res_t              core_res;
	core_status_t           core_status;

	assign out_free     = !valid_s2 || !result_stall;
	assign proc         = valid_s1 && out_free;
	assign sample_stall = valid_s1 && !out_free;
	assign accept       = sample_valid && !sample_stall;

	assign core_req.proc   = proc;
	assign core_req.recal  = (action_s1 == ACT_RECAL);
	assign core_req.sample = sample_s1;

	bdt_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (core_req),
		.threshold (threshold_q),
		.res       (core_res),
		.status    (core_status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RESET;
		end else if (threshold_we) begin
			threshold_q <= threshold_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (proc) begin
			valid_s1 <= 1'b0;
		end
	end

	// The sign bit is flipped on entry to make the sample offset binary.
	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1 <= action;
			sample_s1 <= raw_code ^ SAMPLE_SIGN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= core_res.has_result;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && core_res.has_result) begin
			trigger_s2     <= core_res.trigger;
			sample_high_s2 <= core_res.sample_high;
		end
	end

	assign result_valid = valid_s2;
	assign trigger      = trigger_s2;
	assign sample_high  = sample_high_s2;

	`BDT_ASSERT_NEXT(a_result_lands, clk, arst_n, core_res.has_result && out_free, result_valid, "result from the tracking phase was not registered")
	`BDT_ASSERT_NOW(a_stall_cause, clk, arst_n, sample_stall, valid_s1 && result_valid && result_stall, "input stalled without a blocked result")
	`BDT_ASSERT_NOW(a_fill_range, clk, arst_n, 1'b1, core_status.fill_count <= LAST_SLOT, "fill count ran past the window")
	`BDT_ASSERT_NOW(a_track_count, clk, arst_n, !core_status.filling, core_status.fill_count == '0, "fill count not cleared in tracking phase")

endmodule

// ===== tb/sv/tb_baseline_deviation_trigger.sv =====
// Self-checking testbench for baseline_deviation_trigger: a directed table, then random words
// over several threshold settings, checked by the bench's baseline tracker or typed rows.
// Depends on bdt_pkg and the RTL of the block.
module tb_baseline_deviation_trigger;
	timeunit 1ns;
	timeprecision 1ps;

	import bdt_pkg::*;

	localparam int CYCLE_LIMIT    = 400000;
	localparam int LONG_HOLD      = 300;
	localparam int WORDS_PER_STEP = 200;
	localparam int SETTLE_CYCLES  = 8;

	typedef struct packed {
		logic        trigger;
		logic [15:0] sample_high;
	} result_t;

	typedef struct packed {
		action_t                act;
		logic [SAMPLE_BITS-1:0] code;
		logic [5:0]             reps;
		logic                   typed;
		logic                   trigger;
		logic [15:0]            sample_high;
	} stim_row_t;

	localparam stim_row_t DIRECTED [9] = '{
		'{ACT_SAMPLE, 24'h800013, 6'd1,  1'b0, 1'b0, 16'h0000},
		'{ACT_SAMPLE, 24'h800000, 6'd19, 1'b0, 1'b0, 16'h0000},
		'{ACT_SAMPLE, 24'h800000, 6'd1,  1'b1, 1'b0, 16'h0000},
		'{ACT_SAMPLE, 24'h7FFFFF, 6'd1,  1'b1, 1'b1, 16'hFFFF},
		'{ACT_SAMPLE, 24'h800000, 6'd1,  1'b1, 1'b1, 16'h0000},
		'{ACT_SAMPLE, 24'h000000, 6'd1,  1'b0, 1'b0, 16'h0000},
		'{ACT_RECAL,  24'hFFFFFF, 6'd1,  1'b0, 1'b0, 16'h0000},
		'{ACT_SAMPLE, 24'h123456, 6'd1,  1'b0, 1'b0, 16'h0000},
		'{ACT_RECAL,  24'h000000, 6'd1,  1'b0, 1'b0, 16'h0000}
	};

	logic                   clk;
	logic                   arst_n;
	logic                   threshold_we;
	logic [THRESH_W-1:0]    threshold_wdata;
	logic                   sample_valid;
	logic                   sample_stall;
	logic                   action;
	logic [SAMPLE_BITS-1:0] raw_code;
	logic                   result_valid;
	logic                   result_stall;
	logic                   trigger;
	logic [15:0]            sample_high;

	logic [SAMPLE_BITS-1:0] window_samples [WINDOW];
	int                     write_slot;
	int                     fill_count;
	logic [31:0]            running_sum;
	logic [SAMPLE_BITS-1:0] baseline;
	logic                   filling;
	logic [THRESH_W-1:0]    threshold;

	result_t pending_results [$];

	int  errors;
	int  cycles;
	int  words_sent;
	int  recal_count;
	int  results_checked;
	int  trigger_count;
	int  thresholds_set;
	bit  tx_burst;
	bit  rx_burst;
	bit  rx_taken;
	bit  hold_armed;
	int  stall_left;

	baseline_deviation_trigger u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.threshold_we    (threshold_we),
		.threshold_wdata (threshold_wdata),
		.sample_valid    (sample_valid),
		.sample_stall    (sample_stall),
		.action          (action),
		.raw_code        (raw_code),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.trigger         (trigger),
		.sample_high     (sample_high)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic void track_word(input action_t act, input logic [SAMPLE_BITS-1:0] code,
			output bit produced, output result_t res);
		logic [SAMPLE_BITS-1:0] s;
		logic [SAMPLE_BITS-1:0] diff;
		logic [SAMPLE_BITS-1:0] oldest;
		logic [31:0]            t;
		produced = 1'b0;
		res      = '0;
		if (act == ACT_RECAL) begin
			filling     = 1'b1;
			fill_count  = 0;
			write_slot  = 0;
			running_sum = '0;
			return;
		end
		s = code ^ SAMPLE_SIGN;
		if (filling) begin
			window_samples[fill_count] = s;
			running_sum = running_sum + 32'(s);
			fill_count++;
			if (fill_count == WINDOW) begin
				baseline    = SAMPLE_BITS'(running_sum / WINDOW);
				running_sum = 32'(baseline) * WINDOW;
				write_slot  = 0;
				fill_count  = 0;
				filling     = 1'b0;
			end
			return;
		end
		diff = (s > baseline) ? s - baseline : baseline - s;
		res.trigger     = (diff > threshold);
		res.sample_high = s[SAMPLE_BITS-1 -: 16];
		oldest = window_samples[write_slot];
		window_samples[write_slot] = s;
		t = running_sum + 32'(s);
		running_sum = (t >= 32'(oldest)) ? t - 32'(oldest) : '0;
		write_slot  = (write_slot == WINDOW - 1) ? 0 : write_slot + 1;
		baseline    = SAMPLE_BITS'(running_sum / WINDOW);
		produced    = 1'b1;
	endfunction

	function automatic logic [SAMPLE_BITS-1:0] pick_code();
		longint span;
		longint v;
		int     sel;
		sel  = $urandom_range(0, 99);
		span = (threshold > 24'h3FFFFF) ? 64'hFFFFFF : 2 * longint'(threshold) + 16;
		if (sel < 15) begin
			v = longint'($urandom_range(0, 24'hFFFFFF));
		end else if (sel < 27) begin
			v = ($urandom_range(0, 1) != 0) ? longint'(baseline) + longint'(threshold)
			                                : longint'(baseline) - longint'(threshold);
			v = v + longint'($urandom_range(0, 2)) - 1;
		end else if (sel < 32) begin
			v = ($urandom_range(0, 1) != 0) ? 64'hFFFFFF : 64'h0;
		end else begin
			v = longint'(baseline) + longint'($urandom_range(0, 32'(2 * span))) - span;
		end
		if (v < 0)
			v = 0;
		if (v > 64'hFFFFFF)
			v = 64'hFFFFFF;
		return SAMPLE_BITS'(v) ^ SAMPLE_SIGN;
	endfunction

	task automatic send_word(input action_t act, input logic [SAMPLE_BITS-1:0] code,
			input bit typed, input result_t typed_res);
		int      gap;
		bit      produced;
		result_t res;
		gap = tx_burst ? 0 : $urandom_range(0, 7);
		@(negedge clk);
		repeat (gap) begin
			sample_valid = 1'b0;
			@(negedge clk);
		end
		sample_valid = 1'b1;
		action       = act;
		raw_code     = code;
		@(posedge clk);
		while (sample_stall)
			@(posedge clk);
		track_word(act, code, produced, res);
		if (produced)
			pending_results.push_back(typed ? typed_res : res);
		words_sent++;
		if (act == ACT_RECAL)
			recal_count++;
		if ($urandom_range(0, 39) == 0)
			tx_burst = !tx_burst;
	endtask

	task automatic wait_idle();
		@(negedge clk);
		sample_valid = 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_threshold(input logic [THRESH_W-1:0] value);
		wait_idle();
		@(negedge clk);
		threshold_we    = 1'b1;
		threshold_wdata = value;
		@(negedge clk);
		threshold_we = 1'b0;
		threshold    = value;
		thresholds_set++;
	endtask

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result with none expected: trigger %0b sample_high %h",
					$time, trigger, sample_high);
				errors++;
			end else begin
				result_t want;
				want = pending_results.pop_front();
				if (trigger !== want.trigger) begin
					$display("%0t: trigger mismatch: expected %0b actual %0b",
						$time, want.trigger, trigger);
					errors++;
				end
				if (sample_high !== want.sample_high) begin
					$display("%0t: sample_high mismatch: expected %h actual %h",
						$time, want.sample_high, sample_high);
					errors++;
				end
			end
			results_checked++;
			if (trigger === 1'b1)
				trigger_count++;
			rx_taken = 1'b1;
		end
	end

	always @(negedge clk) begin
		if (rx_taken) begin
			rx_taken   = 1'b0;
			stall_left = rx_burst ? 0 : $urandom_range(0, 7);
		end
		if (hold_armed) begin
			hold_armed = 1'b0;
			stall_left = LONG_HOLD;
		end
		if ($urandom_range(0, 63) == 0)
			rx_burst = !rx_burst;
		if (stall_left > 0) begin
			result_stall <= 1'b1;
			stall_left--;
		end else begin
			result_stall <= 1'b0;
		end
	end

	initial begin
		logic [THRESH_W-1:0] settings [6];
		result_t             typed_res;
		action_t             act;
		arst_n          = 1'b0;
		threshold_we    = 1'b0;
		threshold_wdata = '0;
		sample_valid    = 1'b0;
		action          = ACT_SAMPLE;
		raw_code        = '0;
		result_stall    = 1'b0;
		errors          = 0;
		cycles          = 0;
		words_sent      = 0;
		recal_count     = 0;
		results_checked = 0;
		trigger_count   = 0;
		thresholds_set  = 0;
		tx_burst        = 1'b0;
		rx_burst        = 1'b0;
		rx_taken        = 1'b0;
		hold_armed      = 1'b0;
		stall_left      = 0;
		foreach (window_samples[i])
			window_samples[i] = '0;
		write_slot  = 0;
		fill_count  = 0;
		running_sum = '0;
		baseline    = '0;
		filling     = 1'b1;
		threshold   = THRESHOLD_RESET;

		settings[0] = THRESHOLD_RESET;
		settings[1] = '0;
		settings[2] = 24'hFFFFFF;
		settings[3] = 24'd1;
		settings[4] = THRESH_W'($urandom_range(0, 16'hFFFF));
		settings[5] = THRESH_W'($urandom_range(0, 24'hFFFFFF));

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (DIRECTED[r]) begin
			typed_res.trigger     = DIRECTED[r].trigger;
			typed_res.sample_high = DIRECTED[r].sample_high;
			repeat (DIRECTED[r].reps)
				send_word(DIRECTED[r].act, DIRECTED[r].code, DIRECTED[r].typed, typed_res);
		end

		for (int step = 0; step < 6; step++) begin
			if (step > 0)
				write_threshold(settings[step]);
			for (int n = 0; n < WORDS_PER_STEP; n++) begin
				if (step == 2 && n == WORDS_PER_STEP / 2)
					hold_armed = 1'b1;
				act = ($urandom_range(0, 79) == 0) ? ACT_RECAL : ACT_SAMPLE;
				send_word(act, (act == ACT_RECAL) ? SAMPLE_BITS'($urandom()) : pick_code(),
					1'b0, '0);
			end
		end

		wait_idle();
		repeat (10) @(posedge clk);

		$display("Sent %0d words (%0d recalibrations) over %0d threshold writes.",
			words_sent, recal_count, thresholds_set);
		$display("Checked %0d results, %0d of them with the trigger set; %0d errors.",
			results_checked, trigger_count, errors);
		if (errors == 0 && pending_results.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
